// ===== rtl/nfabv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfabv_pkg
// Shared constants, codes and helpers of the bit-parallel NFA simulator.
// ----------------------------------------------------------------------------
package nfabv_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_SYMBOLS = 256;

    localparam int MASK_W   = 16;
    localparam int ACTION_W = 2;
    localparam int SRC_W    = 4;
    localparam int SYM_W    = 8;

    localparam int SYM_AW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int STATE_IW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int ROW_W    = NUM_STATES * NUM_STATES;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

    typedef logic [NUM_STATES-1:0] state_set_t;
    typedef logic [ROW_W-1:0]      table_row_t;

    // Maps a 16-bit port mask onto the state set; higher state bits stay clear.
    function automatic state_set_t mask_to_set(input logic [MASK_W-1:0] m);
        state_set_t r;
        r = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            if (i < MASK_W) begin
                r[i] = m[SRC_W'(i)];
            end
        end
        return r;
    endfunction

    // Low 16 bits of a state set, zero filled where the set is narrower.
    function automatic logic [MASK_W-1:0] set_to_mask(input state_set_t s);
        logic [MASK_W-1:0] r;
        r = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < NUM_STATES) begin
                r[i] = s[STATE_IW'(i)];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/nfabv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfabv_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nfabv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/nfa_bitvector_simulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_bitvector_simulator_top
// Bit-parallel NFA simulation over a byte stream with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result side is not backpressured
// and returns one result per item through its execute stage and result register. The
// transition table is held in one memory with one row per symbol that packs
// the destination masks of all states, so a single registered read delivers
// every row needed by a symbol step, and the step is one AND-OR over them.
// An add transfer reads the row, merges the mask and writes it back; a row
// written while a read of the same symbol is issued is forwarded to that read.
// Each row has a valid flag cleared at reset, so the table reads as empty
// right after reset with no clearing pass.
module nfa_bitvector_simulator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // source_state[3:0], symbol[11:4], dest_mask[27:12]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // active_states[15:0], accepted[16], no_states[17]
);

    import nfabv_pkg::*;

    localparam logic REG_INITIAL = 1'b0;
    localparam logic REG_FINAL   = 1'b1;

    // Configuration registers.
    logic [MASK_W-1:0] initial_reg;
    logic [MASK_W-1:0] final_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_reg <= 16'h0001;
            final_reg   <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_INITIAL) begin
                initial_reg <= pwdata[MASK_W-1:0];
            end else begin
                final_reg <= pwdata[MASK_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_INITIAL: prdata[MASK_W-1:0] = initial_reg;
            REG_FINAL:   prdata[MASK_W-1:0] = final_reg;
            default:     prdata = '0;
        endcase
    end

    // Input fields.
    logic [ACTION_W-1:0] in_action;
    logic [SRC_W-1:0]    in_src;
    logic [SYM_W-1:0]    in_sym;
    logic [MASK_W-1:0]   in_dest;
    logic [SYM_AW-1:0]   in_addr;
    logic                in_accept;

    assign in_action = s_tuser;
    assign in_src    = s_tdata[3:0];
    assign in_sym    = s_tdata[11:4];
    assign in_dest   = s_tdata[27:12];
    assign in_addr   = in_sym[SYM_AW-1:0];
    assign in_accept = s_tvalid && s_tready;

    // Execute stage registers.
    logic                p1_valid_reg;
    logic [ACTION_W-1:0] p1_action_reg;
    logic [SRC_W-1:0]    p1_src_reg;
    logic [SYM_W-1:0]    p1_sym_reg;
    state_set_t          p1_dest_reg;
    logic                p1_row_valid_reg;
    logic                p1_fwd_reg;
    table_row_t          p1_fwd_data_reg;

    logic                       out_free;
    logic                       p1_done;
    logic [NUM_SYMBOLS-1:0]     row_valid_reg;
    state_set_t                 active_reg;
    state_set_t                 active_next;
    table_row_t                 ram_rdata;
    table_row_t                 row_eff;
    table_row_t                 row_upd;
    state_set_t                 step_set;
    logic                       sym_ok;
    logic                       src_ok;
    logic                       wr_en;
    logic [SYM_AW-1:0]          wr_addr;

    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic [MASK_W-1:0] res_mask;

    assign out_free = !m_tvalid_reg || m_tready;
    assign p1_done  = p1_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || p1_done;

    assign sym_ok  = 32'(p1_sym_reg) < NUM_SYMBOLS;
    assign src_ok  = 32'(p1_src_reg) < NUM_STATES;
    assign wr_addr = p1_sym_reg[SYM_AW-1:0];
    assign wr_en   = p1_done && (p1_action_reg == ACT_ADD) && sym_ok && src_ok;

    assign row_eff = p1_fwd_reg ? p1_fwd_data_reg :
                     (p1_row_valid_reg ? ram_rdata : '0);

    always_comb begin
        step_set = '0;
        row_upd  = row_eff;
        for (int i = 0; i < NUM_STATES; i++) begin
            if (active_reg[i]) begin
                step_set = step_set | row_eff[i*NUM_STATES +: NUM_STATES];
            end
            if (32'(p1_src_reg) == i) begin
                row_upd[i*NUM_STATES +: NUM_STATES] =
                    row_eff[i*NUM_STATES +: NUM_STATES] | p1_dest_reg;
            end
        end
        if (!sym_ok) begin
            step_set = '0;
        end
    end

    always_comb begin
        case (p1_action_reg)
            ACT_START: active_next = mask_to_set(initial_reg);
            ACT_STEP:  active_next = step_set;
            default:   active_next = active_reg;
        endcase
    end

    nfabv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (row_upd),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            active_reg    <= '0;
        end else begin
            if (in_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_done) begin
                p1_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (p1_done) begin
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_action_reg    <= in_action;
            p1_src_reg       <= in_src;
            p1_sym_reg       <= in_sym;
            p1_dest_reg      <= mask_to_set(in_dest);
            p1_row_valid_reg <= row_valid_reg[in_addr];
            p1_fwd_reg       <= wr_en && (wr_addr == in_addr);
            p1_fwd_data_reg  <= row_upd;
        end
    end

    // Result register.
    assign res_mask = set_to_mask(active_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (p1_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_done) begin
            m_tdata_reg <= {6'b0, (active_next == '0), |(res_mask & final_reg), res_mask};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/tb_nfa_bitvector_simulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfa_bitvector_simulator_top
// Self-checking testbench of the bit-parallel NFA simulator.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty word, steps before any start,
// the unused action code, table entries at the edges of the state and symbol
// ranges and the register extremes. Random words, transition adds and noise
// follow in three phases with different idling on both stream sides and
// different start and accepting sets. A behavioral automaton predicts the
// result of every input transfer, and each result transfer is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_nfa_bitvector_simulator_top;

    import nfabv_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;
    localparam logic [2:0]          REG_INITIAL = 3'd0;
    localparam logic [2:0]          REG_FINAL   = 3'd4;

    typedef struct packed {
        logic              no_states;
        logic              accepted;
        logic [MASK_W-1:0] active_states;
    } nfa_result_t;

    class nfa_scoreboard;
        logic [MASK_W-1:0] dest_rows [NUM_STATES][NUM_SYMBOLS];
        logic [MASK_W-1:0] active_mask;
        logic [MASK_W-1:0] start_mask;
        logic [MASK_W-1:0] accept_mask;
        nfa_result_t       predicted_q[$];
        int                errors;

        function new();
            foreach (dest_rows[i, j]) dest_rows[i][j] = '0;
            active_mask = '0;
            start_mask  = 16'h0001;
            accept_mask = '0;
            errors      = 0;
        endfunction

        function void set_register(logic [2:0] addr, logic [31:0] data);
            case (addr)
                REG_INITIAL: start_mask  = data[MASK_W-1:0];
                REG_FINAL:   accept_mask = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        function void note_input(logic [ACTION_W-1:0] act, logic [SRC_W-1:0] src,
                                 logic [SYM_W-1:0] sym, logic [MASK_W-1:0] dest);
            logic [MASK_W-1:0] next_mask;
            nfa_result_t       res;
            case (act)
                ACT_ADD:   dest_rows[src][sym] |= dest;
                ACT_START: active_mask = start_mask;
                ACT_STEP: begin
                    next_mask = '0;
                    for (int i = 0; i < NUM_STATES; i++) begin
                        if (active_mask[i]) next_mask |= dest_rows[i][sym];
                    end
                    active_mask = next_mask;
                end
                default: ;
            endcase
            res.active_states = active_mask;
            res.accepted      = |(active_mask & accept_mask);
            res.no_states     = (active_mask == '0);
            predicted_q.push_back(res);
        endfunction

        task report_mismatch(string what, logic [MASK_W-1:0] got, logic [MASK_W-1:0] want);
            $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [23:0] data);
            nfa_result_t got;
            nfa_result_t want;
            got = data[17:0];
            if (predicted_q.size() == 0) begin
                report_mismatch("unexpected result", data[MASK_W-1:0], '0);
            end else begin
                want = predicted_q.pop_front();
                if (got.active_states !== want.active_states)
                    report_mismatch("active_states", got.active_states, want.active_states);
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", MASK_W'(got.accepted),
                                    MASK_W'(want.accepted));
                if (got.no_states !== want.no_states)
                    report_mismatch("no_states", MASK_W'(got.no_states),
                                    MASK_W'(want.no_states));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    nfa_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_start    = 1'b0;
    int          hold_left     = 0;
    int          items_sent    = 0;
    logic [7:0]  alphabet [8];

    nfa_bitvector_simulator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: checks each transfer and drives ready for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic [ACTION_W-1:0] act, logic [SRC_W-1:0] src,
                             logic [SYM_W-1:0] sym, logic [MASK_W-1:0] dest);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, dest, sym, src};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_input(act, src, sym, dest);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(addr, data);
        @(posedge aclk);
    endtask

    task automatic set_sets(logic [MASK_W-1:0] start_set, logic [MASK_W-1:0] accept_set);
        wait_drained();
        apb_write(REG_INITIAL, {16'h0000, start_set});
        apb_write(REG_FINAL, {16'h0000, accept_set});
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(99) < 85) return alphabet[$urandom_range(7)];
        return SYM_W'($urandom_range(255));
    endfunction

    function automatic logic [MASK_W-1:0] sparse_mask();
        logic [MASK_W-1:0] m;
        m = '0;
        if ($urandom_range(99) < 5) return MASK_W'($urandom);
        m[$urandom_range(15)] = 1'b1;
        if ($urandom_range(1) == 1) m[$urandom_range(15)] = 1'b1;
        return m;
    endfunction

    task automatic run_phase(int n_items, int tx_idle, int rx_idle,
                             logic [MASK_W-1:0] start_set, logic [MASK_W-1:0] accept_set,
                             bit with_pressure);
        int first;
        int word_len;
        int pick;
        bit held;
        bit paused;
        set_sets(start_set, accept_set);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        first  = items_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (items_sent - first < n_items) begin
            if (with_pressure && !held && items_sent - first >= 40) begin
                hold_start = 1'b1;
                held       = 1'b1;
            end
            if (with_pressure && !paused && items_sent - first >= 250) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_item(ACT_ADD, SRC_W'($urandom_range(15)), pick_symbol(), sparse_mask());
            end else if (pick < 18) begin
                send_item(ACTION_W'($urandom_range(3)), SRC_W'($urandom),
                          SYM_W'($urandom), MASK_W'($urandom));
            end else begin
                send_item(ACT_START, SRC_W'($urandom), SYM_W'($urandom), MASK_W'($urandom));
                word_len = $urandom_range(1, 10);
                repeat (word_len) begin
                    send_item(ACT_STEP, SRC_W'($urandom), pick_symbol(), MASK_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(255));
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset register values first.
        send_item(ACT_STEP, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_NONE, 4'hF, 8'hFF, 16'hFFFF);
        send_item(ACT_START, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_ADD, 4'h0, 8'h00, 16'hFFFF);
        send_item(ACT_ADD, 4'hF, 8'hFF, 16'h8000);
        send_item(ACT_ADD, 4'h0, 8'hFF, 16'h0001);
        send_item(ACT_ADD, 4'h7, 8'h5A, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'hFF, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'hFF, 16'h0000);
        send_item(ACT_NONE, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'h5A, 16'h0000);
        set_sets(16'h0000, 16'hFFFF);
        send_item(ACT_START, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'h00, 16'h0000);
        set_sets(16'h8000, 16'hFFFF);
        send_item(ACT_START, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'hFF, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'h00, 16'h0000);
        set_sets(16'hFFFF, 16'h0000);
        send_item(ACT_START, 4'h0, 8'h00, 16'h0000);
        send_item(ACT_STEP, 4'h0, 8'h00, 16'h0000);

        run_phase(476, 21, 77, 16'h0001, 16'h8000, 1'b0);
        run_phase(476, 77, 21, MASK_W'($urandom), MASK_W'($urandom), 1'b0);
        run_phase(476, 0, 0, 16'hFFFF, 16'h0F0F, 1'b1);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nfabv_pkg.sv
rtl/nfabv_ram.sv
rtl/nfa_bitvector_simulator_top.sv
dv/tb_nfa_bitvector_simulator_top.sv
